/* rtl/core/urdf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urdf_pkg: shared types and constants for the UART register datagram framer
// Function codes, controller states, command/status bundles and the CRC-8
// byte update used by the datapath.
// ----------------------------------------------------------------------------
package urdf_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned REG_W  = 7;
	localparam int unsigned NODE_W = 2;
	localparam int unsigned FUNC_W = 2;
	localparam int unsigned IDX_W  = 3;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RX    = 2'd2;

	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h05;
	localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h07;

	localparam logic [IDX_W-1:0] IDX_SYNC     = 3'd0;
	localparam logic [IDX_W-1:0] IDX_NODE     = 3'd1;
	localparam logic [IDX_W-1:0] IDX_REG      = 3'd2;
	localparam logic [IDX_W-1:0] IDX_D3       = 3'd3;
	localparam logic [IDX_W-1:0] IDX_D2       = 3'd4;
	localparam logic [IDX_W-1:0] IDX_D1       = 3'd5;
	localparam logic [IDX_W-1:0] IDX_D0       = 3'd6;
	localparam logic [IDX_W-1:0] IDX_WR_CRC   = 3'd7;
	localparam logic [IDX_W-1:0] IDX_RD_CRC   = 3'd3;
	localparam logic [IDX_W-1:0] RX_FIRST_DAT = 3'd3;
	localparam logic [IDX_W-1:0] RX_LAST_DAT  = 3'd6;
	localparam logic [IDX_W-1:0] RX_FINAL     = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEND,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic start_wr;
		logic start_rd;
		logic rx_take;
		logic tx_advance;
		logic send;
		logic reply;
	} cmd_t;

	typedef struct packed {
		logic last_tx;
		logic rx_final;
	} status_t;

	function automatic logic [BYTE_W-1:0] crc8_feed(
		input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b
	);
		logic [BYTE_W-1:0] c;
		c = crc;
		for (int j = 0; j < BYTE_W; j++) begin
			if (c[BYTE_W-1] ^ b[j]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/urdf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urdf_ctrl: framer controller
// Accepts one request or reply byte at a time and sequences transmit bytes
// and reply results through the datapath.
// ----------------------------------------------------------------------------
module urdf_ctrl
	import urdf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic              out_ready,
	input  wire status_t           status,
	output cmd_t                   cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_WRITE || func == FUNC_READ) begin
						state_nxt = ST_SEND;
					end else if (func == FUNC_RX && status.rx_final) begin
						state_nxt = ST_REPLY;
					end
				end
			end
			ST_SEND: begin
				if (out_ready && status.last_tx) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_REPLY: begin
				if (out_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.start_wr   = accept && (func == FUNC_WRITE);
		cmd.start_rd   = accept && (func == FUNC_READ);
		cmd.rx_take    = accept && (func == FUNC_RX);
		cmd.send       = (state_q == ST_SEND);
		cmd.tx_advance = (state_q == ST_SEND) && out_ready;
		cmd.reply      = (state_q == ST_REPLY);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tx_advance && status.last_tx) |=> (state_q == ST_IDLE))
		else $error("controller did not return to idle after final byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rx_take && status.rx_final) |=> (state_q == ST_REPLY))
		else $error("eighth reply byte did not raise a reply result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start_wr || cmd.start_rd) |=> cmd.send)
		else $error("request accepted but no transmit started");

endmodule
`default_nettype wire

/* rtl/core/urdf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urdf_dp: framer datapath
// Holds the request fields, byte index and running CRC-8, the node address
// register and the reply collector, and forms the result fields.
// ----------------------------------------------------------------------------
module urdf_dp
	import urdf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [NODE_W-1:0] cfg_wdata,
	input  wire logic [REG_W-1:0]  reg_address,
	input  wire logic [DATA_W-1:0] write_data,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire cmd_t              cmd,
	output status_t                status,
	output logic                   out_valid,
	output logic [BYTE_W-1:0]      tx_byte,
	output logic                   tx_valid,
	output logic                   last,
	output logic [DATA_W-1:0]      reply_data,
	output logic                   reply_valid
);

	logic [NODE_W-1:0] node_q;
	logic              is_wr_q;
	logic [REG_W-1:0]  reg_q;
	logic [DATA_W-1:0] data_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] crc_q;
	logic [IDX_W-1:0]  rx_cnt_q;
	logic [DATA_W-1:0] rx_shift_q;
	logic [BYTE_W-1:0] cur_byte;

	always_comb begin
		case (idx_q)
			IDX_SYNC: cur_byte = SYNC_BYTE;
			IDX_NODE: cur_byte = {{(BYTE_W-NODE_W){1'b0}}, node_q};
			IDX_REG:  cur_byte = {is_wr_q, reg_q};
			IDX_D3:   cur_byte = is_wr_q ? data_q[31:24] : crc_q;
			IDX_D2:   cur_byte = data_q[23:16];
			IDX_D1:   cur_byte = data_q[15:8];
			IDX_D0:   cur_byte = data_q[7:0];
			default:  cur_byte = crc_q;
		endcase
	end

	assign status.last_tx  = is_wr_q ? (idx_q == IDX_WR_CRC) : (idx_q == IDX_RD_CRC);
	assign status.rx_final = (rx_cnt_q == RX_FINAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
		end else if (cfg_we) begin
			node_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_wr || cmd.start_rd) begin
			is_wr_q <= cmd.start_wr;
			reg_q   <= reg_address;
			data_q  <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= '0;
		end else if (cmd.start_wr || cmd.start_rd) begin
			idx_q <= '0;
			crc_q <= '0;
		end else if (cmd.tx_advance) begin
			idx_q <= idx_q + 1'b1;
			crc_q <= crc8_feed(crc_q, cur_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_cnt_q   <= '0;
			rx_shift_q <= '0;
		end else if (cmd.start_rd) begin
			rx_cnt_q   <= '0;
			rx_shift_q <= '0;
		end else if (cmd.rx_take) begin
			rx_cnt_q <= rx_cnt_q + 1'b1;
			if (rx_cnt_q >= RX_FIRST_DAT && rx_cnt_q <= RX_LAST_DAT) begin
				rx_shift_q <= {rx_shift_q[DATA_W-BYTE_W-1:0], rx_byte};
			end
		end
	end

	assign out_valid   = cmd.send || cmd.reply;
	assign tx_byte     = cmd.send ? cur_byte : '0;
	assign tx_valid    = cmd.send;
	assign last        = (cmd.send && status.last_tx) || cmd.reply;
	assign reply_data  = cmd.reply ? rx_shift_q : '0;
	assign reply_valid = cmd.reply;

endmodule
`default_nettype wire

/* rtl/core/uart_register_datagram_framer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Latency: a request starts its first byte the cycle after the transfer in.
// Throughput: a write request sends 8 bytes, a read request 4; reply bytes
// are collected and the eighth raises a reply result. One CRC-8 byte update
// per cycle while out_ready is high sets the byte rate; one item at a time.
// Reset: arst_n clears the controller, CRC, byte index, reply collector and
// node address at once; no clearing pass.
// ----------------------------------------------------------------------------
// uart_register_datagram_framer: single-wire UART register datagram framer
// Builds write/read request datagrams with CRC-8 and collects reply bytes
// into a 32-bit register value.
// ----------------------------------------------------------------------------
module uart_register_datagram_framer
	import urdf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [NODE_W-1:0] cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [REG_W-1:0]  reg_address,
	input  wire logic [DATA_W-1:0] write_data,
	input  wire logic [BYTE_W-1:0] rx_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      tx_byte,
	output logic                   tx_valid,
	output logic                   last,
	output logic [DATA_W-1:0]      reply_data,
	output logic                   reply_valid
);

	cmd_t    cmd;
	status_t status;

	urdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	urdf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.reg_address (reg_address),
		.write_data  (write_data),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.tx_byte     (tx_byte),
		.tx_valid    (tx_valid),
		.last        (last),
		.reply_data  (reply_data),
		.reply_valid (reply_valid)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a result is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(tx_valid && reply_valid))
		else $error("transmit byte and reply result at once");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> in_ready)
		else $error("not ready for input after final transfer");

endmodule
`default_nettype wire
